// File: design/b64qd_pkg.sv
// b64qd_pkg: shared types, constants and the character decode function
// for the base64 quad decoder. No dependencies.
package b64qd_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned CNT_W      = 3;
  localparam logic [7:0]  PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0]  PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0]  SLASH_CHAR = 8'h2F;  // '/'

  // Per-lane classification of one character.
  typedef struct packed {
    logic [5:0] sextet;
    logic       pad;
    logic       bad;
  } lane_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] byte_count;
    logic       bad_input;
    logic       message_end;
  } res_t;

  // Sextet value of an alphabet character; valid flag low when outside it.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'd0;
    if (ch inside {[8'h41:8'h5A]}) begin
      t = ch - 8'h41;
      return {1'b1, t[5:0]};
    end else if (ch inside {[8'h61:8'h7A]}) begin
      t = ch - 8'd71;
      return {1'b1, t[5:0]};
    end else if (ch inside {[8'h30:8'h39]}) begin
      t = ch + 8'd4;
      return {1'b1, t[5:0]};
    end else if (ch == PLUS_CHAR) begin
      return {1'b1, 6'd62};
    end else if (ch == SLASH_CHAR) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

// File: design/b64qd_lane.sv
// b64qd_lane: classifies one character of the group (sextet, pad, bad).
// Depends on b64qd_pkg.
module b64qd_lane (
  input  logic [7:0]       char_i,
  output b64qd_pkg::lane_t lane_o
);
  import b64qd_pkg::*;

  logic [6:0] dec;

  always_comb begin
    dec           = sextet_of(char_i);
    lane_o.pad    = (char_i == PAD_CHAR);
    lane_o.sextet = dec[5:0];
    lane_o.bad    = ~dec[6] & ~lane_o.pad;
  end

endmodule

// File: design/b64qd_merge.sv
// b64qd_merge: combines the lane results into bytes and a count, and keeps
// the sticky pad and error flags. Depends on b64qd_pkg.
module b64qd_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  b64qd_pkg::lane_t [3:0]   lanes_i,
  input  logic [2:0]               char_count_i,
  input  logic                     last_group_i,
  output b64qd_pkg::res_t          res_o
);
  import b64qd_pkg::*;

  logic       pad_q, pad_d;
  logic       err_q, err_d;
  logic       run;
  logic       hit_pad, hit_bad;
  logic [2:0] dec;
  logic [1:0] nbytes;
  logic       err_now;
  logic [5:0] v [LANES];

  always_comb begin
    run     = ~pad_q & ~err_q;
    dec     = 3'd0;
    hit_pad = 1'b0;
    hit_bad = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      v[i] = 6'd0;
      if (run && (char_count_i > CNT_W'(i))) begin
        if (lanes_i[i].pad) begin
          hit_pad = 1'b1;
          run     = 1'b0;
        end else if (lanes_i[i].bad) begin
          hit_bad = 1'b1;
          run     = 1'b0;
        end else begin
          v[i] = lanes_i[i].sextet;
          dec  = dec + 3'd1;
        end
      end else begin
        run = 1'b0;
      end
    end

    err_now = err_q | hit_bad;
    nbytes  = (dec >= 3'd2 && !err_now) ? 2'(dec - 3'd1) : 2'd0;

    res_o.byte0       = (nbytes >= 2'd1) ? {v[0], v[1][5:4]} : 8'd0;
    res_o.byte1       = (nbytes >= 2'd2) ? {v[1][3:0], v[2][5:2]} : 8'd0;
    res_o.byte2       = (nbytes == 2'd3) ? {v[2][1:0], v[3]} : 8'd0;
    res_o.byte_count  = nbytes;
    res_o.bad_input   = err_now;
    res_o.message_end = last_group_i;

    // flags clear once the final group of a message is through
    pad_d = pad_q;
    err_d = err_q;
    if (accept_i) begin
      pad_d = last_group_i ? 1'b0 : (pad_q | hit_pad);
      err_d = last_group_i ? 1'b0 : err_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= 1'b0;
      err_q <= 1'b0;
    end else begin
      pad_q <= pad_d;
      err_q <= err_d;
    end
  end

endmodule

// File: design/base64_quad_decoder.sv
// base64_quad_decoder: top level; four decode lanes, a merge stage with the
// sticky flags, and an output register backed by a skid register.
// Depends on b64qd_pkg, b64qd_lane, b64qd_merge.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  input   | in_valid_i, in_stall_o, char0_i.. | in
//          | char3_i, char_count_i, last_group_i
//  output  | out_valid_o, out_stall_i, byte0_o | out
//          | ..byte2_o, byte_count_o, bad_input_o, message_end_o
//
// One group per cycle while in_stall_o is low; results are registered in the
// output or skid register. The four lanes decode in parallel and the merge
// stage resolves the first pad or invalid character in the same cycle.
// Reset clears the sticky flags and both output registers' valid bits.
// in_stall_o rises only when the skid register is full, so one more group
// is taken while a result waits on a stalled output.
module base64_quad_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char0_i,
  input  logic [7:0] char1_i,
  input  logic [7:0] char2_i,
  input  logic [7:0] char3_i,
  input  logic [2:0] char_count_i,
  input  logic       last_group_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte0_o,
  output logic [7:0] byte1_o,
  output logic [7:0] byte2_o,
  output logic [1:0] byte_count_o,
  output logic       bad_input_o,
  output logic       message_end_o
);
  import b64qd_pkg::*;

  lane_t [3:0] lanes;
  logic  [7:0] chars [LANES];
  res_t        res_new;
  res_t        out_q, out_d;
  res_t        skid_q, skid_d;
  logic        out_v_q, out_v_d;
  logic        skid_v_q, skid_v_d;
  logic        accept;
  logic        out_free;

  assign chars[0] = char0_i;
  assign chars[1] = char1_i;
  assign chars[2] = char2_i;
  assign chars[3] = char3_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    b64qd_lane u_lane (
      .char_i (chars[g]),
      .lane_o (lanes[g])
    );
  end

  b64qd_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .lanes_i      (lanes),
    .char_count_i (char_count_i),
    .last_group_i (last_group_i),
    .res_o        (res_new)
  );

  // input transfer whenever the skid slot is empty
  assign in_stall_o = skid_v_q;
  assign accept     = in_valid_i & ~skid_v_q;
  // output register is free when empty or being taken this cycle
  assign out_free   = ~out_v_q | ~out_stall_i;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (out_free) begin
      // skid holds the older result; it drains first
      out_d    = skid_v_q ? skid_q : res_new;
      out_v_d  = skid_v_q | accept;
      skid_v_d = 1'b0;
    end else if (accept) begin
      skid_d   = res_new;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_v_q;
  assign byte0_o       = out_q.byte0;
  assign byte1_o       = out_q.byte1;
  assign byte2_o       = out_q.byte2;
  assign byte_count_o  = out_q.byte_count;
  assign bad_input_o   = out_q.bad_input;
  assign message_end_o = out_q.message_end;

endmodule
